FILE: rtl/per_core_load_percent_core_assert.svh
// Assertion macros shared by the per-core load block.
`ifndef PER_CORE_LOAD_PERCENT_CORE_ASSERT_SVH
`define PER_CORE_LOAD_PERCENT_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PCLP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pclp: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define PCLP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pclp: next-cycle check failed");

`endif

FILE: rtl/pclp_pkg.sv
// Types and constants for the per-core load block.
package pclp_pkg;

	localparam int CORE_W    = 3;
	localparam int TICK_W    = 48;
	localparam int N_TICKS   = 10;
	localparam int IDLE_IDX  = 3;
	localparam int SUM_W     = 52;
	localparam int DIFF_W    = 53;
	localparam int ALU_W     = 59;
	localparam int PCT_W     = 7;
	localparam int CNT_W     = 4;
	localparam int DIV_STEPS = 8;
	localparam int STORE_W   = 2 * SUM_W;

	localparam int IN_TDATA_W  = ((CORE_W + N_TICKS * TICK_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((CORE_W + PCT_W + 7) / 8) * 8;

	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
	localparam logic [CNT_W-1:0] SUM_LAST = 4'(N_TICKS - 1);
	localparam logic [CNT_W-1:0] MUL_LAST = 4'd1;
	localparam logic [CNT_W-1:0] DIV_FIRST = 4'(DIV_STEPS - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_BUSY,
		ST_DBUSY,
		ST_DTOT,
		ST_INC,
		ST_NBUSY,
		ST_ABSB,
		ST_ABST,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	// Sequencer to datapath
	typedef struct packed {
		state_t           st;
		logic [CNT_W-1:0] cnt;
		logic             accept;
		logic             ld_out;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic in_range;
		logic zero_res;
		logic div_carry;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/pclp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pclp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/pclp_alu.sv
// Shared add/subtract unit with carry out, used for every arithmetic step.
module pclp_alu (
	input  logic [pclp_pkg::ALU_W-1:0] a,
	input  logic [pclp_pkg::ALU_W-1:0] b,
	input  logic                       sub,
	output logic [pclp_pkg::ALU_W-1:0] y,
	output logic                       cout
);
	import pclp_pkg::*;

	logic [ALU_W:0]   sum;
	logic [ALU_W-1:0] b_eff;

	// Invert the second operand and add one for a subtract
	assign b_eff = sub ? ~b : b;
	assign sum   = {1'b0, a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, sub};
	assign y     = sum[ALU_W-1:0];
	assign cout  = sum[ALU_W];

endmodule

FILE: rtl/pclp_seq.sv
// Sequencer that steps the shared unit through one sample.
module pclp_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pclp_pkg::stat_t stat,
	output pclp_pkg::ctrl_t ctrl
);
	import pclp_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             accept;
	logic             ld_out;

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		accept  = 1'b0;
		ld_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					accept  = 1'b1;
					cnt_d   = '0;
					state_d = stat.in_range ? ST_SUM : ST_DONE;
				end
			end
			ST_SUM: begin
				if (cnt_q == SUM_LAST) begin
					state_d = ST_BUSY;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_BUSY:  state_d = ST_DBUSY;
			ST_DBUSY: state_d = ST_DTOT;
			ST_DTOT:  state_d = ST_INC;
			ST_INC:   state_d = ST_NBUSY;
			ST_NBUSY: state_d = ST_ABSB;
			ST_ABSB:  state_d = ST_ABST;
			ST_ABST: begin
				cnt_d   = '0;
				state_d = stat.zero_res ? ST_DONE : ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == MUL_LAST) begin
					cnt_d   = DIV_FIRST;
					state_d = ST_DIV;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIV: begin
				// Quotient of 128 or more clamps at once
				if ((cnt_q == DIV_FIRST && stat.div_carry) || cnt_q == '0) begin
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign ctrl.st     = state_q;
	assign ctrl.cnt    = cnt_q;
	assign ctrl.accept = accept;
	assign ctrl.ld_out = ld_out;

endmodule

FILE: rtl/per_core_load_percent_core.sv
// Per-core load block: top level with datapath registers, state store and output register.
//
// Input channel s_axis: one request carries a core index and ten cumulative
// tick counters. Output channel m_axis: one result per request, the core
// index and the busy share since that core's previous sample, 0..100 percent.
// Each sample runs through a single shared add/subtract unit under a small
// sequencer: ten accumulate steps, seven difference and sign steps, two
// multiply-by-100 steps and up to eight restoring divide steps. A quotient
// of 128 or more clamps after the first divide step; a sample with no
// positive quotient skips the multiply and divide steps, and one whose core
// index is not below CORES goes straight to its result. s_axis_tready is
// low while a sample is in work, so a new request is accepted only once the
// previous one has finished.
// Per-core previous totals and busy counts sit in a RAM of CORES entries;
// a valid bit per entry, cleared at reset, makes unwritten entries read as
// zero, so no clearing pass is needed after reset.
// The result waits in an output register; when the receiver stalls, the
// next request is still accepted and worked, and its result then waits with
// s_axis_tready low until the held result leaves.
module per_core_load_percent_core #(
	parameter int CORES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// core_index, user, nice, system, idle, iowait, hardirq, softirq,
	// steal, guest, guest_nice ticks (lowest bits first), zero padded
	input  logic [pclp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// core_out, load_percent (lowest bits first), zero padded
	output logic [pclp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import pclp_pkg::*;

	localparam int AW = (CORES > 1) ? $clog2(CORES) : 1;
	localparam int XW = (AW > CORE_W) ? AW : CORE_W;

	ctrl_t ctrl;
	stat_t stat;

	logic [CORE_W-1:0]  in_core;
	logic [TICK_W-1:0]  in_tick [N_TICKS];
	logic [XW-1:0]      in_core_ext;
	logic [AW-1:0]      in_addr;
	logic               in_range;

	logic [CORE_W-1:0]  core_q;
	logic [AW-1:0]      addr_q;
	logic               in_range_q;
	logic [TICK_W-1:0]  tick_q [N_TICKS];
	logic [TICK_W-1:0]  idle_q;
	logic [SUM_W-1:0]   acc_q;
	logic [SUM_W-1:0]   busy_q;
	logic [DIFF_W-1:0]  dbusy_q;
	logic [DIFF_W-1:0]  dtot_q;
	logic               eq_q;
	logic               zero_res_q;
	logic               clamp_q;
	logic [ALU_W-1:0]   rem_q;
	logic [ALU_W-1:0]   dsh_q;
	logic [PCT_W-1:0]   quo_q;
	logic               prior_vld_q;
	logic [CORES-1:0]   vld_q;

	logic [CORE_W-1:0]  m_core_q;
	logic [PCT_W-1:0]   m_load_q;
	logic               m_valid_q;
	logic [PCT_W-1:0]   load_d;

	logic [STORE_W-1:0] rd_data;
	logic [SUM_W-1:0]   prior_total;
	logic [SUM_W-1:0]   prior_busy;
	logic               ram_we;

	logic [ALU_W-1:0]   alu_a, alu_b, alu_y;
	logic               alu_sub, alu_cout;

	// Unpack the request
	assign in_core = s_axis_tdata[CORE_W-1:0];
	for (genvar i = 0; i < N_TICKS; i++) begin : g_unpack
		assign in_tick[i] = s_axis_tdata[CORE_W + i*TICK_W +: TICK_W];
	end
	assign in_core_ext = XW'(in_core);
	assign in_addr     = in_core_ext[AW-1:0];
	assign in_range    = ({{(32-CORE_W){1'b0}}, in_core} < 32'(CORES));

	pclp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	assign stat.in_range  = in_range;
	assign stat.zero_res  = zero_res_q;
	assign stat.div_carry = alu_cout;
	assign stat.out_free  = !m_valid_q || m_axis_tready;

	// Previous values for the core; unwritten entries read as zero
	assign ram_we      = (ctrl.st == ST_NBUSY);
	assign prior_total = prior_vld_q ? rd_data[STORE_W-1:SUM_W] : '0;
	assign prior_busy  = prior_vld_q ? rd_data[SUM_W-1:0] : '0;

	pclp_ram #(
		.WIDTH (STORE_W),
		.DEPTH (CORES),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata ({acc_q, alu_y[SUM_W-1:0]}),
		.re    (ctrl.accept),
		.raddr (in_addr),
		.rdata (rd_data)
	);

	// Entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			prior_vld_q <= 1'b0;
		end else begin
			if (ram_we) begin
				vld_q[addr_q] <= 1'b1;
			end
			if (ctrl.accept) begin
				prior_vld_q <= in_range ? vld_q[in_addr] : 1'b0;
			end
		end
	end

	// Operand selection for the shared unit
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (ctrl.st)
			ST_SUM: begin
				alu_a = ALU_W'(acc_q);
				alu_b = ALU_W'(tick_q[0]);
			end
			ST_BUSY, ST_NBUSY: begin
				alu_a   = ALU_W'(acc_q);
				alu_b   = ALU_W'(idle_q);
				alu_sub = 1'b1;
			end
			ST_DBUSY: begin
				alu_a   = ALU_W'(busy_q);
				alu_b   = ALU_W'(prior_busy);
				alu_sub = 1'b1;
			end
			ST_DTOT: begin
				alu_a   = ALU_W'(acc_q);
				alu_b   = ALU_W'(prior_total);
				alu_sub = 1'b1;
			end
			ST_INC: begin
				alu_a = ALU_W'(acc_q);
				alu_b = ALU_W'(eq_q);
			end
			ST_ABSB: begin
				alu_b   = {{(ALU_W-DIFF_W){dbusy_q[DIFF_W-1]}}, dbusy_q};
				alu_sub = 1'b1;
			end
			ST_ABST: begin
				alu_b   = {{(ALU_W-DIFF_W){dtot_q[DIFF_W-1]}}, dtot_q};
				alu_sub = 1'b1;
			end
			ST_MUL: begin
				// 100 x = 64 x + 32 x + 4 x
				if (ctrl.cnt == '0) begin
					alu_a = ALU_W'({dbusy_q[SUM_W-1:0], 6'b0});
					alu_b = ALU_W'({dbusy_q[SUM_W-1:0], 5'b0});
				end else begin
					alu_a = rem_q;
					alu_b = ALU_W'({dbusy_q[SUM_W-1:0], 2'b0});
				end
			end
			ST_DIV: begin
				alu_a   = rem_q;
				alu_b   = dsh_q;
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	pclp_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.sub  (alu_sub),
		.y    (alu_y),
		.cout (alu_cout)
	);

	// Datapath registers
	always_ff @(posedge clk) begin
		case (ctrl.st)
			ST_IDLE: begin
				if (ctrl.accept) begin
					core_q     <= in_core;
					addr_q     <= in_addr;
					in_range_q <= in_range;
					tick_q     <= in_tick;
					idle_q     <= in_tick[IDLE_IDX];
					acc_q      <= '0;
					zero_res_q <= !in_range;
					clamp_q    <= 1'b0;
					quo_q      <= '0;
				end
			end
			ST_SUM: begin
				// Accumulate and advance the tick line
				acc_q <= alu_y[SUM_W-1:0];
				for (int i = 0; i < N_TICKS - 1; i++) begin
					tick_q[i] <= tick_q[i+1];
				end
				tick_q[N_TICKS-1] <= '0;
			end
			ST_BUSY:  busy_q  <= alu_y[SUM_W-1:0];
			ST_DBUSY: dbusy_q <= alu_y[DIFF_W-1:0];
			ST_DTOT: begin
				dtot_q <= alu_y[DIFF_W-1:0];
				eq_q   <= (alu_y == '0);
			end
			ST_INC: begin
				// Bump an unchanged total so the delta is one
				acc_q <= alu_y[SUM_W-1:0];
				if (eq_q) begin
					dtot_q <= DIFF_W'(1);
				end
			end
			ST_ABSB: begin
				zero_res_q <= (dbusy_q[DIFF_W-1] != dtot_q[DIFF_W-1]) || (dbusy_q == '0);
				if (dbusy_q[DIFF_W-1]) begin
					dbusy_q <= alu_y[DIFF_W-1:0];
				end
			end
			ST_ABST: begin
				if (dtot_q[DIFF_W-1]) begin
					dtot_q <= alu_y[DIFF_W-1:0];
				end
			end
			ST_MUL: begin
				rem_q <= alu_y;
				dsh_q <= ALU_W'({dtot_q[SUM_W-1:0], 7'b0});
			end
			ST_DIV: begin
				dsh_q <= dsh_q >> 1;
				if (ctrl.cnt == DIV_FIRST) begin
					clamp_q <= alu_cout;
				end else begin
					quo_q <= {quo_q[PCT_W-2:0], alu_cout};
					if (alu_cout) begin
						rem_q <= alu_y;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Clamp the quotient into 0..100
	always_comb begin
		if (zero_res_q) begin
			load_d = '0;
		end else if (clamp_q || quo_q > PCT_MAX) begin
			load_d = PCT_MAX;
		end else begin
			load_d = quo_q;
		end
	end

	// Output register: hold until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctrl.ld_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_out) begin
			m_core_q <= core_q;
			m_load_q <= load_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({m_load_q, m_core_q});

	`include "per_core_load_percent_core_assert.svh"

	`PCLP_ASSERT_SAME(a_load_range, m_axis_tvalid, m_load_q <= PCT_MAX)
	`PCLP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`PCLP_ASSERT_SAME(a_write_in_range, ram_we, in_range_q)

endmodule
